// ===== hw/rtl/fever_alarm_monitor_assert.svh =====
// Assertion macros used by the fever alarm monitor top level.
`ifndef FEVER_ALARM_MONITOR_ASSERT_SVH
`define FEVER_ALARM_MONITOR_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FAM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define FAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fam_pkg.sv =====
// Shared types and constants of the fever alarm monitor.
package fam_pkg;

    // Fixed timing and temperature offset.
    localparam logic [31:0] SETTLE_TICKS = 32'd20000;
    localparam logic [5:0]  TEMP_BASE    = 6'd35;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] CFG_WARN_TEMP        = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DANGER_HIGH_TEMP = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DANGER_LOW_TEMP  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WARN_DELAY       = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REMIND_PERIOD    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_REMIND_PULSE     = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_DANGER_ON        = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_DANGER_OFF       = 4'd7;

    // Health status codes.
    localparam logic [1:0] HS_NORMAL  = 2'd0;
    localparam logic [1:0] HS_WARNING = 2'd1;
    localparam logic [1:0] HS_DANGER  = 2'd2;

    // Phase of the alert sequencer.
    typedef enum logic [2:0] {
        PH_SETTLE,
        PH_MONITOR,
        PH_REMIND,
        PH_DANGER_ON,
        PH_DANGER_OFF
    } fam_phase_t;

    // Configuration register set.
    typedef struct packed {
        logic [5:0]  warn_temp;
        logic [5:0]  danger_high_temp;
        logic [5:0]  danger_low_temp;
        logic [23:0] warn_delay_ticks;
        logic [23:0] reminder_period_ticks;
        logic [23:0] reminder_pulse_ticks;
        logic [23:0] danger_on_ticks;
        logic [23:0] danger_off_ticks;
    } fam_cfg_t;

    // One tick beat.
    typedef struct packed {
        logic [2:0] adc_lines;
        logic       button_edge;
    } fam_in_t;

    // One result beat.
    typedef struct packed {
        logic       motor_on;
        logic       led_on;
        logic       buzzer_level;
        logic [1:0] health_status;
    } fam_out_t;

endpackage

// ===== hw/rtl/fever_alarm_monitor.sv =====
// Top level of the fever alarm monitor: input register, tick logic, output register.
// One beat on the input channel is one 50 us tick; each tick yields exactly one
// result beat with the motor, LED and buzzer levels and the health status. The
// block takes one tick per clock cycle while out_stall is low. An accepted tick
// moves from the input register to the output register once the output slot is
// free or being emptied. The whole per-tick update is a single pass of compares
// and 32-bit subtractions between those two registers. A new tick can be taken
// while a finished result still waits on the output, as long as the input
// register is empty. Configuration registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no tick is in
// flight, which the block does not enforce. Indexes past 7 are ignored.
`include "fever_alarm_monitor_assert.svh"

module fever_alarm_monitor (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  fam_pkg::fam_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output fam_pkg::fam_out_t                  out_data,
    input  logic                               cfg_we,
    input  logic [fam_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fam_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fam_pkg::*;

    logic      in_vld_reg,  in_vld_next;
    fam_in_t   in_data_reg;
    logic      out_vld_reg, out_vld_next;
    fam_out_t  out_data_reg;
    fam_out_t  result;
    fam_cfg_t  cfg;
    logic      in_accept;
    logic      advance;

    fam_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fam_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick_en (advance),
        .tick    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // A held tick moves on whenever the output slot is free or being emptied.
    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // Occupancy of both registers.
    always_comb
    begin
        in_vld_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        out_vld_next = advance ? 1'b1 : (out_stall ? out_vld_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // Checks on the beat flow and the result encoding.
    `FAM_ASSERT_NOW(a_no_overwrite, out_vld_reg && out_stall, !advance, "result overwritten while stalled")
    `FAM_ASSERT_NOW(a_stall_only_full, in_stall, in_vld_reg, "input stalled with empty input register")
    `FAM_ASSERT_NEXT(a_advance_fills, advance, out_vld_reg, "processed tick produced no result beat")
    `FAM_ASSERT_NOW(a_status_code, out_vld_reg, out_data_reg.health_status <= HS_DANGER, "undefined health status code")

endmodule

// ===== hw/rtl/fam_cfg.sv =====
// Configuration register file of the fever alarm monitor.
module fam_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fam_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fam_pkg::CFG_DATA_W-1:0]     cfg_data,
    output fam_pkg::fam_cfg_t                  cfg
);
    import fam_pkg::*;

    fam_cfg_t cfg_reg;
    fam_cfg_t cfg_next;

    // Write decode; indexes past the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WARN_TEMP:        cfg_next.warn_temp             = cfg_data[5:0];
                CFG_DANGER_HIGH_TEMP: cfg_next.danger_high_temp      = cfg_data[5:0];
                CFG_DANGER_LOW_TEMP:  cfg_next.danger_low_temp       = cfg_data[5:0];
                CFG_WARN_DELAY:       cfg_next.warn_delay_ticks      = cfg_data;
                CFG_REMIND_PERIOD:    cfg_next.reminder_period_ticks = cfg_data;
                CFG_REMIND_PULSE:     cfg_next.reminder_pulse_ticks  = cfg_data;
                CFG_DANGER_ON:        cfg_next.danger_on_ticks       = cfg_data;
                CFG_DANGER_OFF:       cfg_next.danger_off_ticks      = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // Registers with their power-on defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warn_temp             <= 6'd38;
            cfg_reg.danger_high_temp      <= 6'd40;
            cfg_reg.danger_low_temp       <= 6'd36;
            cfg_reg.warn_delay_ticks      <= 24'd40000;
            cfg_reg.reminder_period_ticks <= 24'd200000;
            cfg_reg.reminder_pulse_ticks  <= 24'd10000;
            cfg_reg.danger_on_ticks       <= 24'd20000;
            cfg_reg.danger_off_ticks      <= 24'd40000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/fam_core.sv =====
// Per-tick state update of the fever alarm monitor: timers, classifier, alert sequencer.
module fam_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_en,
    input  fam_pkg::fam_in_t    tick,
    input  fam_pkg::fam_cfg_t   cfg,
    output fam_pkg::fam_out_t   result
);
    import fam_pkg::*;

    logic [31:0] elapsed_reg,     elapsed_next;
    logic [1:0]  status_reg,      status_next;
    logic        warn_armed_reg,  warn_armed_next;
    logic [31:0] warn_start_reg,  warn_start_next;
    logic [31:0] last_rem_reg,    last_rem_next;
    fam_phase_t  phase_reg,       phase_next;
    logic [31:0] phase_start_reg, phase_start_next;
    logic        buzzer_reg,      buzzer_next;
    logic        motor_reg,       motor_next;
    logic        led_reg,         led_next;

    logic [31:0] t;
    logic [31:0] d_phase;
    logic [31:0] d_warn;
    logic [31:0] d_remind;
    logic [5:0]  temp;

    fam_phase_t  ph_mid;
    logic [31:0] ps_mid;
    logic        clr_motor;
    logic        clr_led;
    logic        sample_en;

    logic [1:0]  st;
    logic        armed;
    logic [31:0] ws;
    logic        remind_fire;

    // Tick time and the elapsed-time differences, all modulo 2^32.
    assign t        = elapsed_reg + 32'd1;
    assign d_phase  = t - phase_start_reg;
    assign d_warn   = t - warn_start_reg;
    assign d_remind = t - last_rem_reg;
    assign temp     = TEMP_BASE + {3'b000, ~tick.adc_lines};

    // End any wait that has run out this tick.
    always_comb
    begin
        ph_mid    = phase_reg;
        ps_mid    = phase_start_reg;
        clr_motor = 1'b0;
        clr_led   = 1'b0;
        unique case (phase_reg)
            PH_SETTLE:
            begin
                if (d_phase >= SETTLE_TICKS)
                    ph_mid = PH_MONITOR;
            end
            PH_REMIND:
            begin
                if (d_phase >= {8'd0, cfg.reminder_pulse_ticks})
                begin
                    clr_motor = 1'b1;
                    clr_led   = 1'b1;
                    ph_mid    = PH_MONITOR;
                end
            end
            PH_DANGER_ON:
            begin
                if (d_phase >= {8'd0, cfg.danger_on_ticks})
                begin
                    clr_motor = 1'b1;
                    ps_mid    = t;
                    // The off wait starts now, so only a zero length ends it too.
                    if (cfg.danger_off_ticks == 24'd0)
                        ph_mid = PH_MONITOR;
                    else
                        ph_mid = PH_DANGER_OFF;
                end
            end
            PH_DANGER_OFF:
            begin
                if (d_phase >= {8'd0, cfg.danger_off_ticks})
                    ph_mid = PH_MONITOR;
            end
            default:
            begin
                ph_mid = PH_MONITOR;
            end
        endcase
    end

    assign sample_en = (ph_mid == PH_MONITOR);

    // Classify the sample.
    always_comb
    begin
        st    = status_reg;
        armed = warn_armed_reg;
        ws    = warn_start_reg;
        if (temp < cfg.danger_low_temp || temp > cfg.danger_high_temp)
            st = HS_DANGER;
        if (temp >= cfg.danger_low_temp && temp <= cfg.warn_temp)
        begin
            st    = HS_NORMAL;
            armed = 1'b0;
        end
        if (temp > cfg.warn_temp && st != HS_DANGER)
        begin
            if (!armed)
            begin
                ws    = t;
                armed = 1'b1;
            end
            // A timer armed on this tick has seen zero ticks so far.
            if ((warn_armed_reg ? d_warn : 32'd0) > {8'd0, cfg.warn_delay_ticks})
                st = HS_WARNING;
        end
        remind_fire = (st == HS_NORMAL) && (d_remind > {8'd0, cfg.reminder_period_ticks});
    end

    // Next phase of the alert sequencer.
    always_comb
    begin
        phase_next       = ph_mid;
        phase_start_next = ps_mid;
        if (sample_en)
        begin
            if (remind_fire)
            begin
                phase_next       = PH_REMIND;
                phase_start_next = t;
            end
            else if (st != HS_NORMAL && st != HS_WARNING)
            begin
                phase_next       = PH_DANGER_ON;
                phase_start_next = t;
            end
        end
    end

    // Drive levels, status and timers.
    always_comb
    begin
        elapsed_next    = t;
        buzzer_next     = buzzer_reg ^ tick.button_edge;
        motor_next      = motor_reg & ~clr_motor;
        led_next        = led_reg & ~clr_led;
        status_next     = status_reg;
        warn_armed_next = warn_armed_reg;
        warn_start_next = warn_start_reg;
        last_rem_next   = last_rem_reg;
        if (sample_en)
        begin
            status_next     = st;
            warn_armed_next = armed;
            warn_start_next = ws;
            case (st)
                HS_NORMAL:
                begin
                    if (remind_fire)
                    begin
                        last_rem_next = t;
                        motor_next    = 1'b1;
                    end
                    else
                    begin
                        motor_next = 1'b0;
                        led_next   = 1'b0;
                    end
                end
                HS_WARNING:
                begin
                    motor_next = 1'b1;
                end
                default:
                begin
                    motor_next = 1'b1;
                    led_next   = 1'b1;
                end
            endcase
        end
    end

    // State registers, updated once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg     <= 32'd0;
            status_reg      <= HS_NORMAL;
            warn_armed_reg  <= 1'b0;
            warn_start_reg  <= 32'd0;
            last_rem_reg    <= 32'd0;
            phase_reg       <= PH_SETTLE;
            phase_start_reg <= 32'd0;
            buzzer_reg      <= 1'b1;
            motor_reg       <= 1'b0;
            led_reg         <= 1'b0;
        end
        else if (tick_en)
        begin
            elapsed_reg     <= elapsed_next;
            status_reg      <= status_next;
            warn_armed_reg  <= warn_armed_next;
            warn_start_reg  <= warn_start_next;
            last_rem_reg    <= last_rem_next;
            phase_reg       <= phase_next;
            phase_start_reg <= phase_start_next;
            buzzer_reg      <= buzzer_next;
            motor_reg       <= motor_next;
            led_reg         <= led_next;
        end
    end

    // Result of this tick: the register values after the update.
    assign result.motor_on      = motor_next;
    assign result.led_on        = led_next;
    assign result.buzzer_level  = buzzer_next;
    assign result.health_status = status_next;

endmodule

// ===== test/fam_scoreboard_pkg.sv =====
// Scoreboard of the fever alarm monitor: tick predictor and store of predicted outputs.
`timescale 1ns / 1ps

package fam_scoreboard_pkg;

    import fam_pkg::*;

    class alarm_scoreboard;

        // Register set as the block sees it.
        fam_cfg_t cfg;

        // Predictor state.
        logic [31:0] tick_count;
        logic [31:0] warn_since;
        logic [31:0] last_remind;
        logic [31:0] phase_since;
        logic [1:0]  health;
        logic        warn_armed;
        fam_phase_t  phase;
        logic        buzzer;
        logic        motor;
        logic        led;

        // Outputs predicted for accepted ticks, oldest first.
        fam_out_t predicted[$];
        int       errors;

        function new();
            cfg.warn_temp             = 6'd38;
            cfg.danger_high_temp      = 6'd40;
            cfg.danger_low_temp       = 6'd36;
            cfg.warn_delay_ticks      = 24'd40000;
            cfg.reminder_period_ticks = 24'd200000;
            cfg.reminder_pulse_ticks  = 24'd10000;
            cfg.danger_on_ticks       = 24'd20000;
            cfg.danger_off_ticks      = 24'd40000;
            tick_count  = '0;
            warn_since  = '0;
            last_remind = '0;
            phase_since = '0;
            health      = HS_NORMAL;
            warn_armed  = 1'b0;
            phase       = PH_SETTLE;
            buzzer      = 1'b1;
            motor       = 1'b0;
            led         = 1'b0;
            errors      = 0;
        endfunction

        // A register write; six-bit registers keep only their low bits.
        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_WARN_TEMP:        cfg.warn_temp             = data[5:0];
                CFG_DANGER_HIGH_TEMP: cfg.danger_high_temp      = data[5:0];
                CFG_DANGER_LOW_TEMP:  cfg.danger_low_temp       = data[5:0];
                CFG_WARN_DELAY:       cfg.warn_delay_ticks      = data;
                CFG_REMIND_PERIOD:    cfg.reminder_period_ticks = data;
                CFG_REMIND_PULSE:     cfg.reminder_pulse_ticks  = data;
                CFG_DANGER_ON:        cfg.danger_on_ticks       = data;
                CFG_DANGER_OFF:       cfg.danger_off_ticks      = data;
                default: ;
            endcase
        endfunction

        function logic [31:0] ticks_since(logic [31:0] mark);
            return tick_count - mark;
        endfunction

        // Classify one temperature sample and start whatever alert it calls for.
        function void take_reading(logic [2:0] adc_lines);
            logic [2:0] code;
            logic [5:0] temp;
            code = ~adc_lines;
            temp = TEMP_BASE + {3'b000, code};

            if (temp < cfg.danger_low_temp || temp > cfg.danger_high_temp)
                health = HS_DANGER;
            if (temp >= cfg.danger_low_temp && temp <= cfg.warn_temp) begin
                health     = HS_NORMAL;
                warn_armed = 1'b0;
            end
            if (temp > cfg.warn_temp && health != HS_DANGER) begin
                if (!warn_armed) begin
                    warn_since = tick_count;
                    warn_armed = 1'b1;
                end
                if (ticks_since(warn_since) > {8'd0, cfg.warn_delay_ticks})
                    health = HS_WARNING;
            end

            case (health)
                HS_NORMAL: begin
                    if (ticks_since(last_remind) > {8'd0, cfg.reminder_period_ticks}) begin
                        last_remind = tick_count;
                        motor       = 1'b1;
                        phase       = PH_REMIND;
                        phase_since = tick_count;
                    end
                    else begin
                        led   = 1'b0;
                        motor = 1'b0;
                    end
                end
                HS_WARNING: motor = 1'b1;
                default: begin
                    led         = 1'b1;
                    motor       = 1'b1;
                    phase       = PH_DANGER_ON;
                    phase_since = tick_count;
                end
            endcase
        endfunction

        // Advance the predictor by one accepted tick and store the output it yields.
        function void note_tick(fam_in_t beat);
            fam_out_t result;
            if (beat.button_edge)
                buzzer = ~buzzer;
            tick_count = tick_count + 32'd1;

            // Finished waits end here, possibly several on the same tick.
            if (phase == PH_SETTLE && ticks_since(phase_since) >= SETTLE_TICKS)
                phase = PH_MONITOR;
            if (phase == PH_REMIND &&
                ticks_since(phase_since) >= {8'd0, cfg.reminder_pulse_ticks}) begin
                motor = 1'b0;
                led   = 1'b0;
                phase = PH_MONITOR;
            end
            if (phase == PH_DANGER_ON &&
                ticks_since(phase_since) >= {8'd0, cfg.danger_on_ticks}) begin
                motor       = 1'b0;
                phase       = PH_DANGER_OFF;
                phase_since = tick_count;
            end
            if (phase == PH_DANGER_OFF &&
                ticks_since(phase_since) >= {8'd0, cfg.danger_off_ticks})
                phase = PH_MONITOR;

            if (phase == PH_MONITOR)
                take_reading(beat.adc_lines);

            result.motor_on      = motor;
            result.led_on        = led;
            result.buzzer_level  = buzzer;
            result.health_status = health;
            predicted.push_back(result);
        endfunction

        // Compare one accepted output beat with the oldest prediction.
        function void check_output(fam_out_t got);
            fam_out_t want;
            if (predicted.size() == 0) begin
                $error("unexpected result beat %b", got);
                errors++;
                return;
            end
            want = predicted.pop_front();
            if (got.motor_on !== want.motor_on) begin
                $error("motor_on: expected %0b, got %0b", want.motor_on, got.motor_on);
                errors++;
            end
            if (got.led_on !== want.led_on) begin
                $error("led_on: expected %0b, got %0b", want.led_on, got.led_on);
                errors++;
            end
            if (got.buzzer_level !== want.buzzer_level) begin
                $error("buzzer_level: expected %0b, got %0b", want.buzzer_level,
                       got.buzzer_level);
                errors++;
            end
            if (got.health_status !== want.health_status) begin
                $error("health_status: expected %0d, got %0d", want.health_status,
                       got.health_status);
                errors++;
            end
        endfunction

        function int outstanding();
            return predicted.size();
        endfunction

    endclass

endpackage

// ===== test/tb_top.sv =====
// Top of the fever alarm monitor testbench: clock, reset, stimulus and result checking.
`timescale 1ns / 1ps

module tb_top;

    import fam_pkg::*;
    import fam_scoreboard_pkg::*;

    // Register sets, fields in struct order:
    // warn, danger high, danger low, warn delay, period, pulse, danger on, danger off.
    localparam fam_cfg_t SET_ALL_MAX = '{6'd63, 6'd63, 6'd0, 24'hFFFFFF, 24'hFFFFFF,
                                         24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
    localparam fam_cfg_t SET_BASELINE = '{6'd38, 6'd40, 6'd36, 24'd5, 24'd12,
                                          24'd3, 24'd4, 24'd6};
    localparam fam_cfg_t SET_ALL_ZERO = '{6'd0, 6'd0, 6'd0, 24'd0, 24'd0,
                                          24'd0, 24'd0, 24'd0};
    localparam fam_cfg_t SET_CROSSED = '{6'd40, 6'd38, 6'd37, 24'd3, 24'd9,
                                         24'd2, 24'd3, 24'd2};
    localparam fam_cfg_t SET_FAST_REMIND = '{6'd63, 6'd63, 6'd0, 24'd0, 24'd0,
                                             24'd0, 24'd5, 24'd5};
    localparam fam_cfg_t SET_QUICK_WARN = '{6'd37, 6'd41, 6'd35, 24'd0, 24'd20,
                                            24'd2, 24'd1, 24'd1};
    localparam fam_cfg_t SET_MIXED = '{6'd39, 6'd41, 6'd36, 24'd10, 24'd30,
                                       24'd8, 24'd6, 24'd9};

    localparam int TICKS_PER_SET = 285;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    fam_in_t                in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    fam_out_t               out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    alarm_scoreboard sb = new();
    int              ticks_sent = 0;
    int              recv_cycles = 0;
    int              hold_left = 0;

    fam_cfg_t plan[6] = '{SET_BASELINE, SET_ALL_ZERO, SET_CROSSED, SET_FAST_REMIND,
                          SET_QUICK_WARN, SET_MIXED};

    // Temperatures of the opening directed walk: both danger limits, a held warm
    // stretch, and recovery.
    int directed_degs[24] = '{37, 37, 37, 37, 35, 36, 42, 41, 40, 39, 39, 39,
                              39, 39, 39, 39, 39, 38, 37, 36, 35, 42, 38, 37};

    fever_alarm_monitor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls, a steady stretch, and a long hold-off that backs
    // the block up into its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (recv_cycles % 6000 == 3000) begin
                out_stall <= 1'b1;
                hold_left = 80;
            end
            else if (recv_cycles % 6000 < 1500)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 13);
            recv_cycles++;
        end
    end

    // Every accepted result beat goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_output(out_data);
    end

    // Converter code that reads back as the given temperature.
    function automatic logic [2:0] adc_for(int deg);
        return ~3'(deg - int'(TEMP_BASE));
    endfunction

    // Offer one tick beat, with random gaps outside the steady stretch.
    task automatic send_tick(input fam_in_t beat);
        while (ticks_sent % 2500 >= 600 && $urandom_range(0, 99) < 13) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_tick(beat);
        ticks_sent++;
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(index, data);
    endtask

    // Write a whole register set; temperature registers carry junk in their upper
    // bits, and one write goes to an index past the last register.
    task automatic load_setting(input fam_cfg_t s);
        logic [CFG_INDEX_W-1:0] junk_index;
        junk_index = CFG_DANGER_OFF + CFG_INDEX_W'($urandom_range(1, 8));
        reg_write(CFG_WARN_TEMP,        {18'($urandom), s.warn_temp});
        reg_write(CFG_DANGER_HIGH_TEMP, {18'($urandom), s.danger_high_temp});
        reg_write(CFG_DANGER_LOW_TEMP,  {18'($urandom), s.danger_low_temp});
        reg_write(CFG_WARN_DELAY,       s.warn_delay_ticks);
        reg_write(CFG_REMIND_PERIOD,    s.reminder_period_ticks);
        reg_write(CFG_REMIND_PULSE,     s.reminder_pulse_ticks);
        reg_write(CFG_DANGER_ON,        s.danger_on_ticks);
        reg_write(CFG_DANGER_OFF,       s.danger_off_ticks);
        reg_write(junk_index,           CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Mostly runs of a steady temperature so that warnings and alert patterns
    // develop, with single noise ticks mixed in.
    task automatic run_random(input int count);
        int      sent;
        int      deg;
        int      run_len;
        fam_in_t beat;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 85) begin
                deg = $urandom_range(35, 42);
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
                repeat (run_len) begin
                    beat.adc_lines   = adc_for(deg);
                    beat.button_edge = ($urandom_range(0, 7) == 0);
                    send_tick(beat);
                    sent++;
                end
            end
            else begin
                beat = fam_in_t'($urandom);
                send_tick(beat);
                sent++;
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        fam_in_t beat;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Largest register values while the sensor settles; nothing can fire.
        load_setting(SET_ALL_MAX);
        for (int i = 0; i < int'(SETTLE_TICKS); i++) begin
            beat = fam_in_t'($urandom);
            send_tick(beat);
        end

        for (int k = 0; k < 6; k++) begin
            wait_drained();
            load_setting(plan[k]);
            if (k == 0) begin
                foreach (directed_degs[j]) begin
                    beat.adc_lines   = adc_for(directed_degs[j]);
                    beat.button_edge = (j % 3 == 0);
                    send_tick(beat);
                end
            end
            run_random(TICKS_PER_SET);
        end

        wait_drained();
        repeat (5) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
